// ===== sv/dmslt_pkg.sv =====
// Shared types, register map and reset values for the dual motion-sensor light trigger.
package dmslt_pkg;

  localparam int TIME_WIDTH_DEF = 32;
  localparam int ADDR_W         = 5;
  localparam int DATA_W         = 32;

  localparam logic [7:0]  PRESET_TOP_RST    = 8'd1;
  localparam logic [7:0]  PRESET_BOTTOM_RST = 8'd2;
  localparam logic [7:0]  PRESET_OFF_RST    = 8'd0;
  localparam logic [31:0] DURATION_RST      = 32'd30000;
  localparam logic        EXTEND_RST        = 1'b1;
  localparam logic        OVERRIDE_RST      = 1'b0;
  localparam logic [15:0] HOLDOFF_RST       = 16'd200;

  typedef enum logic [2:0] {
    REG_PRESET_TOP    = 3'd0,
    REG_PRESET_BOTTOM = 3'd1,
    REG_PRESET_OFF    = 3'd2,
    REG_DURATION      = 3'd3,
    REG_EXTEND        = 3'd4,
    REG_OVERRIDE      = 3'd5,
    REG_HOLDOFF       = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    OWNER_NONE   = 2'd0,
    OWNER_TOP    = 2'd1,
    OWNER_BOTTOM = 2'd2
  } owner_t;

  typedef enum logic [1:0] {
    CAUSE_TOP    = 2'd0,
    CAUSE_BOTTOM = 2'd1,
    CAUSE_OFF    = 2'd2
  } cause_t;

  typedef struct packed {
    logic [7:0]  preset_top;
    logic [7:0]  preset_bottom;
    logic [7:0]  preset_off;
    logic [31:0] duration;
    logic        extend;
    logic        override;
    logic [15:0] holdoff;
  } cfg_t;

  typedef struct packed {
    logic [7:0] preset;
    cause_t     cause;
  } res_t;

  typedef struct packed {
    logic          load;
    logic [1:0]    cnt;
    res_t [2:0]    ent;
  } res_bundle_t;

endpackage

// ===== sv/dmslt_cfg.sv =====
// APB-style configuration register bank.
module dmslt_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dmslt_pkg::ADDR_W-1:0]  paddr,
  input  logic [dmslt_pkg::DATA_W-1:0]  pwdata,
  output logic [dmslt_pkg::DATA_W-1:0]  prdata,
  output logic                          pready,
  output dmslt_pkg::cfg_t               cfg
);
  import dmslt_pkg::*;

  cfg_t     cfg_r;
  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.preset_top    <= PRESET_TOP_RST;
      cfg_r.preset_bottom <= PRESET_BOTTOM_RST;
      cfg_r.preset_off    <= PRESET_OFF_RST;
      cfg_r.duration      <= DURATION_RST;
      cfg_r.extend        <= EXTEND_RST;
      cfg_r.override      <= OVERRIDE_RST;
      cfg_r.holdoff       <= HOLDOFF_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_PRESET_TOP:    cfg_r.preset_top    <= pwdata[7:0];
        REG_PRESET_BOTTOM: cfg_r.preset_bottom <= pwdata[7:0];
        REG_PRESET_OFF:    cfg_r.preset_off    <= pwdata[7:0];
        REG_DURATION:      cfg_r.duration      <= pwdata[31:0];
        REG_EXTEND:        cfg_r.extend        <= pwdata[0];
        REG_OVERRIDE:      cfg_r.override      <= pwdata[0];
        REG_HOLDOFF:       cfg_r.holdoff       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_PRESET_TOP:    prdata = {24'd0, cfg_r.preset_top};
      REG_PRESET_BOTTOM: prdata = {24'd0, cfg_r.preset_bottom};
      REG_PRESET_OFF:    prdata = {24'd0, cfg_r.preset_off};
      REG_DURATION:      prdata = cfg_r.duration;
      REG_EXTEND:        prdata = {31'd0, cfg_r.extend};
      REG_OVERRIDE:      prdata = {31'd0, cfg_r.override};
      REG_HOLDOFF:       prdata = {16'd0, cfg_r.holdoff};
      default:           prdata = '0;
    endcase
  end

endmodule

// ===== sv/dmslt_core.sv =====
// Input register, trigger/effect state and the per-sample decision logic.
module dmslt_core #(
  parameter int TIME_WIDTH = dmslt_pkg::TIME_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dmslt_pkg::cfg_t            cfg,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_top_level,
  input  logic                       in_bottom_level,
  input  logic [31:0]                in_now_ms,
  input  logic                       obuf_free,
  output dmslt_pkg::res_bundle_t     res
);
  import dmslt_pkg::*;

  localparam int CMP_W = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

  logic                  vld_r, vld_nxt;
  logic                  top_r, bot_r;
  logic [31:0]           now_in_r;
  logic [63:0]           now_ext;
  logic [TIME_WIDTH-1:0] now;

  logic [TIME_WIDTH-1:0] top_last_r, bot_last_r, start_r;
  logic                  running_r;
  owner_t                owner_r;

  logic [TIME_WIDTH-1:0] d_top, d_bot, d_eff;
  logic [1:0]            trig;
  logic                  accept, advance;

  logic                  run;
  logic [TIME_WIDTH-1:0] st;
  owner_t                own;
  owner_t                sid;
  logic [1:0]            n;
  res_t [2:0]            ent;

  assign now_ext = {32'd0, now_in_r};
  assign now     = now_ext[TIME_WIDTH-1:0];
  assign d_top   = now - top_last_r;
  assign d_bot   = now - bot_last_r;
  assign trig[0] = top_r && (CMP_W'(d_top) >= CMP_W'(cfg.holdoff));
  assign trig[1] = bot_r && (CMP_W'(d_bot) >= CMP_W'(cfg.holdoff));

  always_comb begin
    run = running_r;
    st  = start_r;
    own = owner_r;
    sid = OWNER_NONE;
    n   = '0;
    ent = '0;
    for (int i = 0; i < 2; i++) begin
      sid = (i == 0) ? OWNER_TOP : OWNER_BOTTOM;
      if (trig[i]) begin
        if (!run) begin
          ent[n].preset = (i == 0) ? cfg.preset_top : cfg.preset_bottom;
          ent[n].cause  = (i == 0) ? CAUSE_TOP : CAUSE_BOTTOM;
          n   = n + 2'd1;
          run = 1'b1;
          st  = now;
          own = sid;
        end else if (cfg.extend && own == sid) begin
          st = now;
        end else if (cfg.override && own != sid) begin
          ent[n].preset = (i == 0) ? cfg.preset_top : cfg.preset_bottom;
          ent[n].cause  = (i == 0) ? CAUSE_TOP : CAUSE_BOTTOM;
          n   = n + 2'd1;
          st  = now;
          own = sid;
        end
      end
    end
    d_eff = now - st;
    if (run && (CMP_W'(d_eff) >= CMP_W'(cfg.duration))) begin
      ent[n].preset = cfg.preset_off;
      ent[n].cause  = CAUSE_OFF;
      n   = n + 2'd1;
      run = 1'b0;
      own = OWNER_NONE;
    end
  end

  // samples with no result never wait on the output buffer
  assign advance  = vld_r && ((n == 2'd0) || obuf_free);
  assign in_stall = vld_r && !advance;
  assign accept   = in_valid && !in_stall;
  assign vld_nxt  = accept ? 1'b1 : (advance ? 1'b0 : vld_r);

  assign res.load = advance && (n != 2'd0);
  assign res.cnt  = n;
  assign res.ent  = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      top_r    <= in_top_level;
      bot_r    <= in_bottom_level;
      now_in_r <= in_now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_last_r <= '0;
      bot_last_r <= '0;
      start_r    <= '0;
      running_r  <= 1'b0;
      owner_r    <= OWNER_NONE;
    end else if (advance) begin
      if (trig[0]) top_last_r <= now;
      if (trig[1]) bot_last_r <= now;
      start_r   <= st;
      running_r <= run;
      owner_r   <= own;
    end
  end

endmodule

// ===== sv/dmslt_obuf.sv =====
// Result buffer: holds up to three preset commands of one sample and sends them in order.
module dmslt_obuf (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dmslt_pkg::res_bundle_t res,
  output logic                   obuf_free,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             out_preset_id,
  output logic [1:0]             out_cause,
  output logic                   out_is_last
);
  import dmslt_pkg::*;

  res_t [2:0] ent_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       take;

  assign out_valid     = (cnt_r != 2'd0);
  assign take          = out_valid && !out_stall;
  assign obuf_free     = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && take);
  assign out_preset_id = ent_r[0].preset;
  assign out_cause     = ent_r[0].cause;
  assign out_is_last   = (cnt_r == 2'd1);

  always_comb begin
    cnt_nxt = cnt_r;
    if (res.load) begin
      cnt_nxt = res.cnt;
    end else if (take) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      ent_r <= res.ent;
    end else if (take) begin
      ent_r[0] <= ent_r[1];
      ent_r[1] <= ent_r[2];
    end
  end

endmodule

// ===== sv/dual_motion_sensor_light_trigger.sv =====
// Top level of the dual motion-sensor light trigger.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   in      | in_valid / in_stall  | in_top_level, in_bottom_level, in_now_ms
//   out     | out_valid / out_stall| out_preset_id, out_cause, out_is_last
//   cfg     | psel/penable/pwrite  | paddr, pwdata, prdata, pready
//
// A sample is registered and decided combinationally, and its 0..3 preset commands go to
// the result buffer once it is free; the first command is offered from the result
// buffer register after it is loaded there and is taken while out_stall is low.
// A sample with k commands holds the result buffer until its last command is taken,
// and the next sample that has commands waits for that; samples with no command
// pass at one per cycle. out_stall holds the buffer and backs up into in_stall.
// Synchronous reset loads register defaults and clears control state, not data registers; no clearing pass.
module dual_motion_sensor_light_trigger #(
  parameter int TIME_WIDTH = dmslt_pkg::TIME_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_top_level,
  input  logic                          in_bottom_level,
  input  logic [31:0]                   in_now_ms,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_preset_id,
  output logic [1:0]                    out_cause,
  output logic                          out_is_last,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dmslt_pkg::ADDR_W-1:0]  paddr,
  input  logic [dmslt_pkg::DATA_W-1:0]  pwdata,
  output logic [dmslt_pkg::DATA_W-1:0]  prdata,
  output logic                          pready
);
  import dmslt_pkg::*;

  cfg_t        cfg;
  res_bundle_t res;
  logic        obuf_free;

  dmslt_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dmslt_core #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_top_level    (in_top_level),
    .in_bottom_level (in_bottom_level),
    .in_now_ms       (in_now_ms),
    .obuf_free       (obuf_free),
    .res             (res)
  );

  dmslt_obuf u_obuf (
    .clk           (clk),
    .rst_n         (rst_n),
    .res           (res),
    .obuf_free     (obuf_free),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_preset_id (out_preset_id),
    .out_cause     (out_cause),
    .out_is_last   (out_is_last)
  );

endmodule

// ===== tb/dmslt_checker.sv =====
`timescale 1ns / 100ps
// Checker for the dual motion-sensor light trigger: predicts and compares every preset command.
module dmslt_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic                         in_top_level,
  input  logic                         in_bottom_level,
  input  logic [31:0]                  in_now_ms,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [7:0]                   out_preset_id,
  input  logic [1:0]                   out_cause,
  input  logic                         out_is_last,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [dmslt_pkg::ADDR_W-1:0] paddr,
  input  logic [dmslt_pkg::DATA_W-1:0] pwdata,
  output int                           err_cnt,
  output int                           pending,
  output int                           cmds_checked
);
  import dmslt_pkg::*;

  typedef struct packed {
    logic [7:0] preset;
    cause_t     cause;
    logic       last;
  } lamp_cmd_t;

  cfg_t        cfg_q;
  logic [31:0] top_last_ms;
  logic [31:0] bottom_last_ms;
  logic [31:0] effect_start_ms;
  logic        effect_on;
  owner_t      effect_owner;
  lamp_cmd_t   burst[$];
  lamp_cmd_t   cmds_due[$];
  int          errs = 0;
  int          checked = 0;

  task automatic fire(input owner_t who, input logic [31:0] now);
    lamp_cmd_t c;
    c.preset = (who == OWNER_TOP) ? cfg_q.preset_top : cfg_q.preset_bottom;
    c.cause  = (who == OWNER_TOP) ? CAUSE_TOP : CAUSE_BOTTOM;
    c.last   = 1'b0;
    if (!effect_on) begin
      burst.push_back(c);
      effect_on       = 1'b1;
      effect_start_ms = now;
      effect_owner    = who;
    end else if (cfg_q.extend && effect_owner == who) begin
      effect_start_ms = now;
    end else if (cfg_q.override && effect_owner != who) begin
      burst.push_back(c);
      effect_start_ms = now;
      effect_owner    = who;
    end
  endtask

  task automatic predict_commands(input logic top, input logic bottom, input logic [31:0] now);
    lamp_cmd_t off;
    burst.delete();
    if (top && (now - top_last_ms) >= 32'(cfg_q.holdoff)) begin
      top_last_ms = now;
      fire(OWNER_TOP, now);
    end
    if (bottom && (now - bottom_last_ms) >= 32'(cfg_q.holdoff)) begin
      bottom_last_ms = now;
      fire(OWNER_BOTTOM, now);
    end
    if (effect_on && (now - effect_start_ms) >= cfg_q.duration) begin
      off.preset = cfg_q.preset_off;
      off.cause  = CAUSE_OFF;
      off.last   = 1'b0;
      burst.push_back(off);
      effect_on    = 1'b0;
      effect_owner = OWNER_NONE;
    end
    if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
    foreach (burst[k]) cmds_due.push_back(burst[k]);
  endtask

  always @(posedge clk) begin
    lamp_cmd_t want;
    if (!rst_n) begin
      cfg_q.preset_top    = PRESET_TOP_RST;
      cfg_q.preset_bottom = PRESET_BOTTOM_RST;
      cfg_q.preset_off    = PRESET_OFF_RST;
      cfg_q.duration      = DURATION_RST;
      cfg_q.extend        = EXTEND_RST;
      cfg_q.override      = OVERRIDE_RST;
      cfg_q.holdoff       = HOLDOFF_RST;
      top_last_ms         = '0;
      bottom_last_ms      = '0;
      effect_start_ms     = '0;
      effect_on           = 1'b0;
      effect_owner        = OWNER_NONE;
      cmds_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[dmslt_pkg::ADDR_W-1:2])
          REG_PRESET_TOP:    cfg_q.preset_top    = pwdata[7:0];
          REG_PRESET_BOTTOM: cfg_q.preset_bottom = pwdata[7:0];
          REG_PRESET_OFF:    cfg_q.preset_off    = pwdata[7:0];
          REG_DURATION:      cfg_q.duration      = pwdata[31:0];
          REG_EXTEND:        cfg_q.extend        = pwdata[0];
          REG_OVERRIDE:      cfg_q.override      = pwdata[0];
          REG_HOLDOFF:       cfg_q.holdoff       = pwdata[15:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_commands(in_top_level, in_bottom_level, in_now_ms);
      if (out_valid && !out_stall) begin
        if (cmds_due.size() == 0) begin
          $error("unexpected transaction: preset_id=%0d cause=%0d is_last=%0d",
                 out_preset_id, out_cause, out_is_last);
          errs++;
        end else begin
          want = cmds_due.pop_front();
          checked++;
          if (out_preset_id !== want.preset) begin
            $error("preset_id: expected %0d, actual %0d", want.preset, out_preset_id);
            errs++;
          end
          if (out_cause !== want.cause) begin
            $error("cause: expected %0d, actual %0d", want.cause, out_cause);
            errs++;
          end
          if (out_is_last !== want.last) begin
            $error("is_last: expected %0d, actual %0d", want.last, out_is_last);
            errs++;
          end
        end
      end
    end
    err_cnt      <= errs;
    pending      <= cmds_due.size();
    cmds_checked <= checked;
  end

endmodule

// ===== tb/tb_dual_motion_sensor_light_trigger.sv =====
`timescale 1ns / 100ps
// Top-level testbench for the dual motion-sensor light trigger: stimulus, idling and verdict.
module tb_dual_motion_sensor_light_trigger;
  import dmslt_pkg::*;

  localparam int         DRAIN_CYCLES = 8;
  localparam int         STALL_LIMIT  = 2000;
  localparam logic [2:0] UNUSED_REG   = 3'd7;

  logic              clk;
  logic              rst_n           = 1'b0;
  logic              in_valid        = 1'b0;
  logic              in_stall;
  logic              in_top_level    = 1'b0;
  logic              in_bottom_level = 1'b0;
  logic [31:0]       in_now_ms       = '0;
  logic              out_valid;
  logic              out_stall       = 1'b0;
  logic [7:0]        out_preset_id;
  logic [1:0]        out_cause;
  logic              out_is_last;
  logic              psel            = 1'b0;
  logic              penable         = 1'b0;
  logic              pwrite          = 1'b0;
  logic [ADDR_W-1:0] paddr           = '0;
  logic [DATA_W-1:0] pwdata          = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int          tx_pct = 12;
  int          rx_pct = 51;
  int          mismatches;
  int          pending;
  int          cmds_checked;
  int          n_samples   = 0;
  int          n_configs   = 1;
  int          idle_cycles = 0;
  logic [31:0] now_track   = '0;

  dual_motion_sensor_light_trigger u_dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_top_level, .in_bottom_level, .in_now_ms,
    .out_valid, .out_stall, .out_preset_id, .out_cause, .out_is_last,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  dmslt_checker u_chk (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_top_level, .in_bottom_level, .in_now_ms,
    .out_valid, .out_stall, .out_preset_id, .out_cause, .out_is_last,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .err_cnt(mismatches), .pending(pending), .cmds_checked(cmds_checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) out_stall <= ($urandom_range(0, 99) < rx_pct);

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_sample(input logic top, input logic bottom, input logic [31:0] now);
    in_valid        <= 1'b1;
    in_top_level    <= top;
    in_bottom_level <= bottom;
    in_now_ms       <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_samples++;
    if ($urandom_range(0, 99) < tx_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < tx_pct) @(posedge clk);
    end
  endtask

  task automatic random_samples(input int count, input int unsigned step_max, input int noise_pct);
    logic [31:0] noise;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        noise = $urandom;
        send_sample(noise[0], noise[1], $urandom);
      end else begin
        now_track += $urandom_range(0, step_max);
        send_sample($urandom_range(0, 99) < 45, $urandom_range(0, 99) < 45, now_track);
      end
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // back-to-back APB writes; the bus is released by load_config
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic load_config(input cfg_t c);
    logic [31:0] junk;
    junk = $urandom;
    write_reg(REG_PRESET_TOP,    {junk[31:8], c.preset_top});
    write_reg(REG_PRESET_BOTTOM, {junk[31:8], c.preset_bottom});
    write_reg(REG_PRESET_OFF,    {junk[31:8], c.preset_off});
    write_reg(REG_DURATION,      c.duration);
    write_reg(REG_EXTEND,        {junk[31:1], c.extend});
    write_reg(REG_OVERRIDE,      {junk[31:1], c.override});
    write_reg(REG_HOLDOFF,       {junk[31:16], c.holdoff});
    write_reg(UNUSED_REG,        $urandom);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    n_configs++;
  endtask

  function automatic cfg_t rand_config();
    cfg_t c;
    c.preset_top    = 8'($urandom);
    c.preset_bottom = 8'($urandom);
    c.preset_off    = 8'($urandom);
    c.duration      = ($urandom_range(0, 9) == 0) ? 32'd0 : 32'($urandom_range(1, 1500));
    c.extend        = 1'($urandom_range(0, 1));
    c.override      = 1'($urandom_range(0, 1));
    c.holdoff       = 16'($urandom_range(0, 300));
    return c;
  endfunction

  initial begin
    cfg_t c;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: early sample, holdoff, extension, ignored trigger, time-out, wrap
    send_sample(1'b1, 1'b1, 32'd100);
    send_sample(1'b1, 1'b0, 32'd200);
    send_sample(1'b1, 1'b0, 32'd300);
    send_sample(1'b1, 1'b0, 32'd400);
    send_sample(1'b0, 1'b1, 32'd500);
    send_sample(1'b0, 1'b0, 32'd30400);
    send_sample(1'b1, 1'b1, 32'd30600);
    send_sample(1'b0, 1'b0, 32'hFFFF_FFFF);
    send_sample(1'b1, 1'b0, 32'h0000_0050);
    now_track = 32'h0000_0050;
    random_samples(15, 400, 10);
    wait_idle();

    // zero duration, zero holdoff, override: start + takeover + off in one sample
    c = '{preset_top: 8'hFF, preset_bottom: 8'h00, preset_off: 8'hAA, duration: 32'd0,
          extend: 1'b0, override: 1'b1, holdoff: 16'd0};
    load_config(c);
    send_sample(1'b0, 1'b0, now_track);
    send_sample(1'b1, 1'b1, now_track + 32'd1);
    send_sample(1'b1, 1'b0, now_track + 32'd1);
    now_track += 32'd1;
    random_samples(15, 50, 0);
    wait_idle();

    tx_pct = 51;
    rx_pct = 12;
    // max duration and holdoff: time-out only one tick short of a full wrap
    c = '{preset_top: 8'h00, preset_bottom: 8'hFF, preset_off: 8'h55,
          duration: 32'hFFFF_FFFF, extend: 1'b1, override: 1'b1, holdoff: 16'hFFFF};
    load_config(c);
    send_sample(1'b0, 1'b1, now_track + 32'h0002_0000);
    send_sample(1'b0, 1'b0, now_track + 32'h0001_FFFF);
    now_track += 32'h0002_0000;
    random_samples(10, 32'h0003_0000, 15);
    wait_idle();

    load_config(rand_config());
    random_samples(20, 400, 15);
    wait_idle();

    tx_pct = 0;
    rx_pct = 0;
    load_config(rand_config());
    random_samples(20, 400, 15);
    wait_idle();

    load_config(rand_config());
    random_samples(20, 400, 15);
    wait_idle();

    $display("Sent %0d sensor samples under %0d register settings; %0d preset commands checked.",
             n_samples, n_configs, cmds_checked);
    $display("Covered holdoff, extension, takeover, zero and maximum duration, and time wrap.");
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
